FILE: rtl/great_circle_destination_unit_assert.svh
// assertion macros for the great circle destination unit
`ifndef GREAT_CIRCLE_DESTINATION_UNIT_ASSERT_SVH
`define GREAT_CIRCLE_DESTINATION_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GCDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gcdu check failed");

// next-cycle implication, disabled in reset
`define GCDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gcdu check failed");

// checked on the cycle after reset is seen
`define GCDU_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk_i) !rst_ni |=> (cons)) \
    else $error("gcdu check failed");

`endif

FILE: rtl/gcdu_pkg.sv
// types and constants of the great circle destination unit
package gcdu_pkg;

  typedef struct packed {
    logic signed [31:0] start_lat;
    logic signed [31:0] start_lon;
    logic [24:0]        travel_distance;
    logic signed [31:0] course;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] dest_lat;
    logic signed [31:0] dest_lon;
  } out_req_t;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic [37:0] TURN_PER_RAD = 38'd174992710547;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  localparam logic [31:0] ATAN_ROM [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

endpackage

FILE: rtl/great_circle_destination_unit.sv
// great circle destination point pipeline: divider, cordic, products, isqrt, atan2
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid_i/in_ready_o | in_req_i (in_req_t)
//   out     | result    | out_valid_o/out_ready_i | out_req_o (out_req_t)
//   cfg     | write     | cfg_we_i              | cfg_data_i (earth radius, meters)
//
// one request per cycle unless stalled; stages: the one-bit-per-stage radius divider,
// the 30-step cordic rows and the 31-step isqrt
// a two-entry output buffer takes results; the whole pipeline holds only when it is full
// reset clears the valid bits and the buffer and loads the radius with 6371000
module great_circle_destination_unit import gcdu_pkg::*; #(
  parameter int ANGLE_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o,
  input  logic     cfg_we_i,
  input  logic [22:0] cfg_data_i
);

  localparam int A     = ANGLE_BITS;
  localparam int CS    = CORDIC_STEPS;
  localparam int DEXT  = (A > 40) ? A - 40 : 0;
  localparam int ND    = 63 + DEXT;
  localparam int QW    = (A > 40) ? A : 40;
  localparam int DSH   = (A < 40) ? 40 - A : 1;
  localparam int NQ    = 31;
  localparam int NS    = ND + 103;
  localparam int FR_UP = (A > 32) ? A - 32 : 0;
  localparam int FR_DN = (A < 32) ? 32 - A : 1;
  localparam int TO_UP = (A < 32) ? 32 - A : 0;
  localparam int TO_DN = (A > 32) ? A - 32 : 1;
  localparam logic [18:0] C_LO = TURN_PER_RAD[18:0];
  localparam logic [18:0] C_HI = TURN_PER_RAD[37:19];
  localparam logic signed [A:0] HALF_S    = (A+1)'(1) <<< (A - 1);
  localparam logic signed [A:0] QUARTER_S = (A+1)'(1) <<< (A - 2);
  localparam logic [A-1:0] HALF_U = A'(1) << (A - 1);

  typedef struct packed {
    logic [A-1:0] lat;
    logic [A-1:0] lon;
    logic [A-1:0] brg;
  } side_t;

  function automatic logic [A-1:0] from32(input logic [31:0] v);
    logic [48:0] w;
    w = 49'(v);
    if (A >= 32) w = w << FR_UP;
    else w = (w + (49'd1 << (FR_DN - 1))) >> FR_DN;
    return w[A-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [A-1:0] v);
    logic [48:0] w;
    w = 49'(v);
    if (A > 32) w = (w + (49'd1 << (TO_DN - 1))) >> TO_DN;
    else w = w << TO_UP;
    return w[31:0];
  endfunction

  function automatic logic [A-1:0] rom_a(input int i);
    return from32(ATAN_ROM[i]);
  endfunction

  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    logic [65:0] m;
    logic signed [32:0] r;
    p = a * b;
    m = p[65] ? 66'(-p) : 66'(p);
    m = (m + (66'd1 << 29)) >> 30;
    r = $signed(m[32:0]);
    return p[65] ? -r : r;
  endfunction

  // control: radius, valid shift, output buffer
  logic [22:0] rad_q, rad_eff;
  logic [NS-1:0] v_q;
  logic en, push, pop;
  logic [1:0] cnt_q;
  logic wr_ptr_q, rd_ptr_q;
  out_req_t fifo_q [2];
  out_req_t push_data;

  assign rad_eff    = (rad_q == '0) ? 23'd1 : rad_q;
  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;
  assign push       = en & v_q[NS-1];
  assign pop        = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q    <= RADIUS_RESET;
      v_q      <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (cfg_we_i) rad_q <= cfg_data_i;
      if (en) v_q <= {v_q[NS-2:0], in_valid_i};
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_data;
  end

  // input conversion and split constant multiply
  side_t s0_side_q, s1_side_q;
  logic [43:0] s0_plo_q, s0_phi_q;
  logic [62:0] s1_num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q.lat <= from32(in_req_i.start_lat);
      s0_side_q.lon <= from32(in_req_i.start_lon);
      s0_side_q.brg <= from32(in_req_i.course);
      s0_plo_q      <= 44'(in_req_i.travel_distance) * 44'(C_LO);
      s0_phi_q      <= 44'(in_req_i.travel_distance) * 44'(C_HI);
      s1_side_q     <= s0_side_q;
      s1_num_q      <= (63'(s0_phi_q) << 19) + 63'(s0_plo_q);
    end
  end

  // restoring divider by the radius, one quotient bit per stage
  logic [23:0]   dv_rem_q [ND];
  logic [ND-1:0] dv_dvd_q [ND];
  logic [QW-1:0] dv_quo_q [ND];
  side_t         dv_side_q [ND];

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [23:0]   rin, r;
    logic [ND-1:0] din;
    logic [QW-1:0] qin;
    side_t         sin;
    logic          ge;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign din = ND'(s1_num_q) << DEXT;
      assign qin = '0;
      assign sin = s1_side_q;
    end else begin : g_next
      assign rin = dv_rem_q[k-1];
      assign din = dv_dvd_q[k-1];
      assign qin = dv_quo_q[k-1];
      assign sin = dv_side_q[k-1];
    end
    assign r  = {rin[22:0], din[ND-1]};
    assign ge = (r >= {1'b0, rad_eff});
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k]  <= ge ? r - {1'b0, rad_eff} : r;
        dv_dvd_q[k]  <= din << 1;
        dv_quo_q[k]  <= {qin[QW-2:0], ge};
        dv_side_q[k] <= sin;
      end
    end
  end

  // angular distance
  logic [A-1:0] d_next, d_q;
  side_t sd_side_q;
  if (A < 40) begin : g_dround
    logic [39:0] dsum;
    assign dsum   = dv_quo_q[ND-1][39:0] + (40'd1 << (DSH - 1));
    assign d_next = A'(dsum >> DSH);
  end else begin : g_dtrunc
    assign d_next = dv_quo_q[ND-1][A-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q       <= d_next;
      sd_side_q <= dv_side_q[ND-1];
    end
  end

  // sine and cosine rows: lat, distance, course
  logic signed [32:0] sc_x_q [3][CS+1];
  logic signed [32:0] sc_y_q [3][CS+1];
  logic signed [A:0]  sc_z_q [3][CS+1];
  logic               sc_flip_q [3][CS+1];
  logic [A-1:0]       sc_lon_q [CS+1];

  for (genvar u = 0; u < 3; u++) begin : g_sc
    logic [A-1:0] ang;
    logic signed [A:0] z0, zp;
    logic fl;
    if (u == 0) begin : g_lat
      assign ang = sd_side_q.lat;
    end else if (u == 1) begin : g_dst
      assign ang = d_q;
    end else begin : g_brg
      assign ang = sd_side_q.brg;
    end
    assign z0 = $signed({ang[A-1], ang});
    always_comb begin
      zp = z0;
      fl = 1'b0;
      if (z0 > QUARTER_S) begin
        zp = z0 - HALF_S;
        fl = 1'b1;
      end else if (z0 < -QUARTER_S) begin
        zp = z0 + HALF_S;
        fl = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sc_x_q[u][0]    <= CORDIC_START;
        sc_y_q[u][0]    <= '0;
        sc_z_q[u][0]    <= zp;
        sc_flip_q[u][0] <= fl;
      end
    end
    for (genvar i = 0; i < CS; i++) begin : g_step
      localparam logic signed [A:0] R = $signed({1'b0, rom_a(i)});
      logic signed [32:0] dx, dy;
      assign dx = sc_y_q[u][i] >>> i;
      assign dy = sc_x_q[u][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (!sc_z_q[u][i][A]) begin
            sc_x_q[u][i+1] <= sc_x_q[u][i] - dx;
            sc_y_q[u][i+1] <= sc_y_q[u][i] + dy;
            sc_z_q[u][i+1] <= sc_z_q[u][i] - R;
          end else begin
            sc_x_q[u][i+1] <= sc_x_q[u][i] + dx;
            sc_y_q[u][i+1] <= sc_y_q[u][i] - dy;
            sc_z_q[u][i+1] <= sc_z_q[u][i] + R;
          end
          sc_flip_q[u][i+1] <= sc_flip_q[u][i];
        end
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_sc_lon
    always_ff @(posedge clk_i) begin
      if (en) sc_lon_q[i+1] <= sc_lon_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) sc_lon_q[0] <= sd_side_q.lon;
  end

  // sign fix and products
  logic signed [32:0] f_sl_q, f_cl_q, f_sd_q, f_cd_q, f_sb_q, f_cb_q;
  logic signed [32:0] p1_m1_q, p1_m2_q, p1_m5_q, p1_sl_q, p1_cl_q, p1_cd_q, p1_cb_q;
  logic signed [32:0] p2_m1_q, p2_m3_q, p2_m6_q, p2_sl_q, p2_cd_q;
  logic signed [32:0] p3_t_q, p3_y_q, p3_sl_q, p3_cd_q;
  logic signed [32:0] p4_m4_q, p4_t_q, p4_y_q, p4_cd_q;
  logic [61:0]        p4_n_q, p5_n_q;
  logic signed [33:0] p5_x_q;
  logic signed [32:0] p5_t_q, p5_y_q;
  logic [A-1:0] f_lon_q, p1_lon_q, p2_lon_q, p3_lon_q, p4_lon_q, p5_lon_q;
  logic signed [33:0] tsum;
  logic signed [32:0] tcl;
  logic signed [65:0] tt;

  assign tsum = 34'(p2_m1_q) + 34'(p2_m3_q);
  always_comb begin
    if (tsum > 34'sd1073741824) tcl = 33'sd1073741824;
    else if (tsum < -34'sd1073741824) tcl = -33'sd1073741824;
    else tcl = 33'(tsum);
  end
  assign tt = p3_t_q * p3_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_cl_q  <= sc_flip_q[0][CS] ? -sc_x_q[0][CS] : sc_x_q[0][CS];
      f_sl_q  <= sc_flip_q[0][CS] ? -sc_y_q[0][CS] : sc_y_q[0][CS];
      f_cd_q  <= sc_flip_q[1][CS] ? -sc_x_q[1][CS] : sc_x_q[1][CS];
      f_sd_q  <= sc_flip_q[1][CS] ? -sc_y_q[1][CS] : sc_y_q[1][CS];
      f_cb_q  <= sc_flip_q[2][CS] ? -sc_x_q[2][CS] : sc_x_q[2][CS];
      f_sb_q  <= sc_flip_q[2][CS] ? -sc_y_q[2][CS] : sc_y_q[2][CS];
      f_lon_q <= sc_lon_q[CS];

      p1_m1_q  <= mulq(f_sl_q, f_cd_q);
      p1_m2_q  <= mulq(f_cl_q, f_sd_q);
      p1_m5_q  <= mulq(f_sb_q, f_sd_q);
      p1_sl_q  <= f_sl_q;
      p1_cl_q  <= f_cl_q;
      p1_cd_q  <= f_cd_q;
      p1_cb_q  <= f_cb_q;
      p1_lon_q <= f_lon_q;

      p2_m1_q  <= p1_m1_q;
      p2_m3_q  <= mulq(p1_m2_q, p1_cb_q);
      p2_m6_q  <= mulq(p1_m5_q, p1_cl_q);
      p2_sl_q  <= p1_sl_q;
      p2_cd_q  <= p1_cd_q;
      p2_lon_q <= p1_lon_q;

      p3_t_q   <= tcl;
      p3_y_q   <= p2_m6_q;
      p3_sl_q  <= p2_sl_q;
      p3_cd_q  <= p2_cd_q;
      p3_lon_q <= p2_lon_q;

      p4_m4_q  <= mulq(p3_sl_q, p3_t_q);
      p4_n_q   <= (62'd1 << 60) - 62'(tt);
      p4_t_q   <= p3_t_q;
      p4_y_q   <= p3_y_q;
      p4_cd_q  <= p3_cd_q;
      p4_lon_q <= p3_lon_q;

      p5_x_q   <= 34'(p4_cd_q) - 34'(p4_m4_q);
      p5_n_q   <= p4_n_q;
      p5_t_q   <= p4_t_q;
      p5_y_q   <= p4_y_q;
      p5_lon_q <= p4_lon_q;
    end
  end

  // integer square root, two radicand bits per stage
  logic [61:0]        q_n_q [NQ];
  logic [61:0]        q_r_q [NQ];
  logic signed [32:0] q_t_q [NQ];
  logic signed [33:0] q_x_q [NQ];
  logic signed [32:0] q_y_q [NQ];
  logic [A-1:0]       q_lon_q [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] nin, rin, sum;
    logic signed [32:0] tin, yin;
    logic signed [33:0] xin;
    logic [A-1:0] lin;
    logic ge;
    if (k == 0) begin : g_first
      assign nin = p5_n_q;
      assign rin = '0;
      assign tin = p5_t_q;
      assign xin = p5_x_q;
      assign yin = p5_y_q;
      assign lin = p5_lon_q;
    end else begin : g_next
      assign nin = q_n_q[k-1];
      assign rin = q_r_q[k-1];
      assign tin = q_t_q[k-1];
      assign xin = q_x_q[k-1];
      assign yin = q_y_q[k-1];
      assign lin = q_lon_q[k-1];
    end
    assign sum = rin + BIT;
    assign ge  = (nin >= sum);
    always_ff @(posedge clk_i) begin
      if (en) begin
        q_n_q[k]   <= ge ? nin - sum : nin;
        q_r_q[k]   <= ge ? (rin >> 1) + BIT : rin >> 1;
        q_t_q[k]   <= tin;
        q_x_q[k]   <= xin;
        q_y_q[k]   <= yin;
        q_lon_q[k] <= lin;
      end
    end
  end

  // atan2 rows: latitude (asin) and longitude change
  logic signed [34:0] a0_x_q [2];
  logic signed [34:0] a0_y_q [2];
  logic [4:0]         a0_s_q [2];
  logic [A-1:0]       a0_z_q [2];
  logic               a0_zero_q [2];
  logic [A-1:0]       a0_lon_q;
  logic signed [34:0] at_x_q [2][CS+1];
  logic signed [34:0] at_y_q [2][CS+1];
  logic [A-1:0]       at_z_q [2][CS+1];
  logic               at_zero_q [2][CS+1];
  logic [A-1:0]       at_lon_q [CS+1];

  for (genvar u = 0; u < 2; u++) begin : g_at
    logic signed [34:0] xin, yin, xn, yn;
    logic [34:0] ay, mm;
    logic [4:0] s;
    logic neg;
    if (u == 0) begin : g_asin
      assign yin = 35'(q_t_q[NQ-1]);
      assign xin = $signed({4'd0, q_r_q[NQ-1][30:0]});
    end else begin : g_dlon
      assign yin = 35'(q_y_q[NQ-1]);
      assign xin = 35'(q_x_q[NQ-1]);
    end
    always_comb begin
      neg = xin[34];
      xn  = neg ? -xin : xin;
      yn  = neg ? -yin : yin;
      ay  = yn[34] ? 35'(-yn) : 35'(yn);
      mm  = 35'(xn) | ay;
      s   = '0;
      for (int j = 4; j >= 0; j--) begin
        if (mm < (35'd1 << (30 - (1 << j)))) begin
          mm = mm << (1 << j);
          s  = s + 5'(1 << j);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        a0_x_q[u]    <= xn;
        a0_y_q[u]    <= yn;
        a0_s_q[u]    <= s;
        a0_z_q[u]    <= neg ? HALF_U : '0;
        a0_zero_q[u] <= (xin == '0) && (yin == '0);
        at_x_q[u][0]    <= a0_x_q[u] <<< a0_s_q[u];
        at_y_q[u][0]    <= a0_y_q[u] <<< a0_s_q[u];
        at_z_q[u][0]    <= a0_z_q[u];
        at_zero_q[u][0] <= a0_zero_q[u];
      end
    end
    for (genvar i = 0; i < CS; i++) begin : g_step
      localparam logic [A-1:0] R = rom_a(i);
      logic signed [34:0] dx, dy;
      assign dx = at_y_q[u][i] >>> i;
      assign dy = at_x_q[u][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (at_y_q[u][i] > 35'sd0) begin
            at_x_q[u][i+1] <= at_x_q[u][i] + dx;
            at_y_q[u][i+1] <= at_y_q[u][i] - dy;
            at_z_q[u][i+1] <= at_z_q[u][i] + R;
          end else begin
            at_x_q[u][i+1] <= at_x_q[u][i] - dx;
            at_y_q[u][i+1] <= at_y_q[u][i] + dy;
            at_z_q[u][i+1] <= at_z_q[u][i] - R;
          end
          at_zero_q[u][i+1] <= at_zero_q[u][i];
        end
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_at_lon
    always_ff @(posedge clk_i) begin
      if (en) at_lon_q[i+1] <= at_lon_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_lon_q    <= q_lon_q[NQ-1];
      at_lon_q[0] <= a0_lon_q;
    end
  end

  // result
  logic [A-1:0] lat2, dlon;
  assign lat2 = at_zero_q[0][CS] ? '0 : at_z_q[0][CS];
  assign dlon = at_zero_q[1][CS] ? '0 : at_z_q[1][CS];
  assign push_data.dest_lat = to32(lat2);
  assign push_data.dest_lon = to32(at_lon_q[CS] + dlon);

endmodule

FILE: rtl/gcdu_checker.sv
// port checker for the great circle destination unit and its bind
module gcdu_checker import gcdu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_req_t out_req_o
);

`include "great_circle_destination_unit_assert.svh"

  `GCDU_ASSERT_NEXT(a_out_valid_held, out_valid_o && !out_ready_i, out_valid_o)
  `GCDU_ASSERT_NEXT(a_out_req_held, out_valid_o && !out_ready_i, $stable(out_req_o))
  `GCDU_ASSERT_NOW(a_stall_only_when_full, !in_ready_o, out_valid_o)
  `GCDU_ASSERT_NEXT(a_stall_needs_backpressure, out_valid_o && out_ready_i, in_ready_o)
  `GCDU_ASSERT_RST(a_no_result_in_reset, !out_valid_o)

endmodule

bind great_circle_destination_unit gcdu_checker u_gcdu_checker (.*);
